// ----- rtl/cpr_pkg.sv -----
// Shared codes and field widths for the clock page replacement unit.
package cpr_pkg;

    // Request operation codes
    localparam logic [1:0] OP_FAULT  = 2'd0;
    localparam logic [1:0] OP_MAP    = 2'd1;
    localparam logic [1:0] OP_UNMAP  = 2'd2;
    localparam logic [1:0] OP_ACCESS = 2'd3;

    // Result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_SEGFAULT = 2'd1;
    localparam logic [1:0] ST_NO_FREE  = 2'd2;

    // Register word index of initial_pages
    localparam logic REG_INITIAL_PAGES = 1'b0;

    // Fixed port field widths
    localparam int PAGE_W  = 10;
    localparam int FRAME_W = 6;
    localparam int INIT_W  = 11;

    // Store sizes, fixed by the page and frame field widths
    localparam int FRAME_COUNT = 64;
    localparam int PAGE_COUNT  = 1024;

endpackage

// ----- rtl/clock_page_replacement_unit.sv -----
// Top level of the clock (second-chance) page replacement unit.
//
// Request channel: operation, page and is_write are taken at a rising edge where
// start is high and busy is low. Each request gives one result, shown for exactly
// one cycle with done high; the receiver cannot stall it.
// Config: APB-style port, initial_pages at byte address 0.
//
// Steps from accept to done:
//   fault hit, segfault, unmap, access: one decode step on the store reads.
//   map: scans the allocation store from initial_pages for the first free page.
//   fault miss: at each occupied frame the hand reaches, the owner-store read
//     followed by the page-store read; a referenced frame is passed (at most
//     FRAME_COUNT), an unreferenced one is evicted, and an empty or evicted frame
//     is then loaded.
// One request is worked on at a time; busy stays high until its result is out.
//
// After reset the unit runs a clearing pass over the page and allocation stores,
// with busy high. A write of initial_pages while idle, clearing or marking marks
// pages below it as allocated, again with busy high.
module clock_page_replacement_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    // request channel
    input  logic                        start,
    output logic                        busy,
    input  logic [1:0]                  operation,
    input  logic [cpr_pkg::PAGE_W-1:0]  page,
    input  logic                        is_write,
    // result channel
    output logic                        done,
    output logic [1:0]                  status,
    output logic [cpr_pkg::FRAME_W-1:0] frame,
    output logic [cpr_pkg::PAGE_W-1:0]  result_page,
    output logic                        evicted,
    output logic [cpr_pkg::PAGE_W-1:0]  evicted_page,
    output logic                        write_back,
    // configuration port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [2:0]                  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    localparam int FRAME_COUNT = cpr_pkg::FRAME_COUNT;
    localparam int PAGE_COUNT  = cpr_pkg::PAGE_COUNT;
    localparam int PW = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
    localparam int FW = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
    localparam int CW = $clog2(PAGE_COUNT + 1);
    localparam int EW = FW + 3;   // {valid, referenced, dirty, frame}
    localparam int PAGE_LAST = PAGE_COUNT - 1;

    typedef enum logic [3:0] {
        S_CLEAR, S_MARK, S_IDLE, S_DECODE, S_MAP, S_HAND, S_OWNER, S_VICTIM, S_LOAD
    } st_t;

    // Page store, allocation store, frame owner store
    logic [EW-1:0] page_mem  [PAGE_COUNT];
    logic          alloc_mem [PAGE_COUNT];
    logic [PW-1:0] owner_mem [FRAME_COUNT];

    logic          pm_we;
    logic [PW-1:0] pm_waddr, pm_raddr;
    logic [EW-1:0] pm_wdata, pm_rdata;
    logic          am_we, am_wdata, am_rdata;
    logic [PW-1:0] am_waddr, am_raddr;
    logic          om_we;
    logic [PW-1:0] om_rdata;

    st_t                        state_reg, state_next;
    logic [1:0]                 op_reg, op_next;
    logic [cpr_pkg::PAGE_W-1:0] pg_reg, pg_next;
    logic                       wr_reg, wr_next;
    logic [FW-1:0]              hand_reg, hand_next;
    logic [FRAME_COUNT-1:0]     occ_reg, occ_next;
    logic [CW-1:0]              idx_reg, idx_next;
    logic [CW-1:0]              limit_reg, limit_next;
    logic [cpr_pkg::INIT_W-1:0] init_reg, init_next;
    logic                       ev_reg, ev_next;
    logic [PW-1:0]              evp_reg, evp_next;
    logic                       wb_reg, wb_next;

    logic                        done_reg, done_next;
    logic [1:0]                  status_reg, status_next;
    logic [cpr_pkg::FRAME_W-1:0] frame_reg, frame_next;
    logic [cpr_pkg::PAGE_W-1:0]  rpage_reg, rpage_next;
    logic                        evo_reg, evo_next;
    logic [cpr_pkg::PAGE_W-1:0]  evpo_reg, evpo_next;
    logic                        wbo_reg, wbo_next;

    logic          accept, cfg_we, inrange;
    logic [31:0]   cfg_lim32;
    logic [CW-1:0] cfg_lim;
    logic [PW-1:0] pg_addr;
    logic          e_valid, e_ref, e_dirty;
    logic [FW-1:0] e_frame;

    function automatic logic [FW-1:0] advance(input logic [FW-1:0] h);
        advance = (h == FW'(FRAME_COUNT - 1)) ? '0 : h + 1'b1;
    endfunction

    assign accept  = start && !busy;
    assign busy    = (state_reg != S_IDLE);
    assign cfg_we  = psel && penable && pwrite && pready
                     && (paddr[2] == cpr_pkg::REG_INITIAL_PAGES);
    assign pready  = 1'b1;
    assign prdata  = (paddr[2] == cpr_pkg::REG_INITIAL_PAGES)
                     ? {{(32 - cpr_pkg::INIT_W){1'b0}}, init_reg} : 32'd0;

    // Clamp the marking bound to the page count
    assign cfg_lim32 = (32'(pwdata[cpr_pkg::INIT_W-1:0]) > 32'(PAGE_COUNT))
                       ? 32'(PAGE_COUNT) : 32'(pwdata[cpr_pkg::INIT_W-1:0]);
    assign cfg_lim   = CW'(cfg_lim32);

    assign pg_addr = PW'(pg_reg);
    assign inrange = (32'(pg_reg) < 32'(PAGE_COUNT));
    assign {e_valid, e_ref, e_dirty, e_frame} = pm_rdata;

    // Next-state and memory port control
    always_comb
    begin
        state_next  = state_reg;
        op_next     = op_reg;
        pg_next     = pg_reg;
        wr_next     = wr_reg;
        hand_next   = hand_reg;
        occ_next    = occ_reg;
        idx_next    = idx_reg;
        limit_next  = limit_reg;
        init_next   = init_reg;
        ev_next     = ev_reg;
        evp_next    = evp_reg;
        wb_next     = wb_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        frame_next  = frame_reg;
        rpage_next  = rpage_reg;
        evo_next    = evo_reg;
        evpo_next   = evpo_reg;
        wbo_next    = wbo_reg;

        pm_we    = 1'b0;
        pm_waddr = pg_addr;
        pm_wdata = pm_rdata;
        pm_raddr = pg_addr;
        am_we    = 1'b0;
        am_waddr = pg_addr;
        am_wdata = 1'b0;
        am_raddr = pg_addr;
        om_we    = 1'b0;

        // Take a register write: keep the wider bound while clearing or marking, else the new one
        if (cfg_we)
        begin
            init_next = pwdata[cpr_pkg::INIT_W-1:0];
            if (state_reg == S_MARK || state_reg == S_CLEAR)
                limit_next = (cfg_lim > limit_reg) ? cfg_lim : limit_reg;
            else
                limit_next = cfg_lim;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                pm_we    = 1'b1;
                pm_waddr = PW'(idx_reg);
                pm_wdata = '0;
                am_we    = 1'b1;
                am_waddr = PW'(idx_reg);
                am_wdata = 1'b0;
                idx_next = idx_reg + 1'b1;
                if (idx_reg == CW'(PAGE_LAST))
                begin
                    idx_next   = '0;
                    state_next = (limit_next != '0) ? S_MARK : S_IDLE;
                end
            end
            S_MARK:
            begin
                am_we    = 1'b1;
                am_waddr = PW'(idx_reg);
                am_wdata = 1'b1;
                idx_next = idx_reg + 1'b1;
                if (cfg_we)
                    idx_next = '0;
                else if (idx_next >= limit_reg)
                begin
                    idx_next   = '0;
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (cfg_we && cfg_lim != '0)
                begin
                    idx_next   = '0;
                    state_next = S_MARK;
                end
                else if (accept)
                begin
                    op_next  = operation;
                    pg_next  = page;
                    wr_next  = is_write;
                    pm_raddr = PW'(page);
                    if (operation == cpr_pkg::OP_MAP)
                    begin
                        idx_next   = CW'(init_reg);
                        am_raddr   = PW'(init_reg);
                        state_next = S_MAP;
                    end
                    else
                    begin
                        am_raddr   = PW'(page);
                        state_next = S_DECODE;
                    end
                end
            end
            S_DECODE:
            begin
                status_next = cpr_pkg::ST_OK;
                frame_next  = '0;
                rpage_next  = pg_reg;
                evo_next    = 1'b0;
                evpo_next   = '0;
                wbo_next    = 1'b0;
                done_next   = 1'b1;
                state_next  = S_IDLE;
                case (op_reg)
                    cpr_pkg::OP_FAULT:
                    begin
                        if (!inrange || !am_rdata)
                            status_next = cpr_pkg::ST_SEGFAULT;
                        else if (e_valid)
                            frame_next = cpr_pkg::FRAME_W'(e_frame);
                        else
                        begin
                            done_next  = 1'b0;
                            ev_next    = 1'b0;
                            evp_next   = '0;
                            wb_next    = 1'b0;
                            state_next = S_HAND;
                        end
                    end
                    cpr_pkg::OP_UNMAP:
                    begin
                        if (inrange && am_rdata)
                        begin
                            if (e_valid)
                                occ_next[e_frame] = 1'b0;
                            pm_we    = 1'b1;
                            pm_wdata = {3'b000, e_frame};
                            am_we    = 1'b1;
                            am_wdata = 1'b0;
                        end
                    end
                    default:
                    begin
                        // Access: mark a resident page referenced, dirty on write
                        rpage_next = '0;
                        if (inrange && e_valid)
                        begin
                            pm_we    = 1'b1;
                            pm_wdata = {1'b1, 1'b1, e_dirty | wr_reg, e_frame};
                        end
                    end
                endcase
            end
            S_MAP:
            begin
                am_raddr = PW'(idx_reg + 1'b1);
                if (idx_reg >= CW'(PAGE_COUNT))
                begin
                    status_next = cpr_pkg::ST_NO_FREE;
                    rpage_next  = '0;
                end
                else if (!am_rdata)
                begin
                    am_we       = 1'b1;
                    am_waddr    = PW'(idx_reg);
                    am_wdata    = 1'b1;
                    status_next = cpr_pkg::ST_OK;
                    rpage_next  = cpr_pkg::PAGE_W'(idx_reg);
                end
                idx_next = idx_reg + 1'b1;
                if (idx_reg >= CW'(PAGE_COUNT) || !am_rdata)
                begin
                    frame_next = '0;
                    evo_next   = 1'b0;
                    evpo_next  = '0;
                    wbo_next   = 1'b0;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_HAND:
            begin
                // Owner store is read at the hand every cycle
                state_next = occ_reg[hand_reg] ? S_OWNER : S_LOAD;
            end
            S_OWNER:
            begin
                pm_raddr   = om_rdata;
                state_next = S_VICTIM;
            end
            S_VICTIM:
            begin
                pm_we    = 1'b1;
                pm_waddr = om_rdata;
                if (e_ref)
                begin
                    // Second chance: clear and move on
                    pm_wdata   = {e_valid, 1'b0, e_dirty, e_frame};
                    hand_next  = advance(hand_reg);
                    state_next = S_HAND;
                end
                else
                begin
                    pm_wdata   = {1'b0, 1'b0, e_dirty, e_frame};
                    ev_next    = 1'b1;
                    evp_next   = om_rdata;
                    wb_next    = e_dirty;
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                pm_we              = 1'b1;
                pm_wdata           = {1'b1, 1'b0, 1'b0, hand_reg};
                om_we              = 1'b1;
                occ_next[hand_reg] = 1'b1;
                hand_next          = advance(hand_reg);
                status_next        = cpr_pkg::ST_OK;
                frame_next         = cpr_pkg::FRAME_W'(hand_reg);
                rpage_next         = pg_reg;
                evo_next           = ev_reg;
                evpo_next          = cpr_pkg::PAGE_W'(evp_reg);
                wbo_next           = wb_reg;
                done_next          = 1'b1;
                state_next         = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLEAR;
            op_reg     <= '0;
            pg_reg     <= '0;
            wr_reg     <= 1'b0;
            hand_reg   <= '0;
            occ_reg    <= '0;
            idx_reg    <= '0;
            limit_reg  <= '0;
            init_reg   <= '0;
            ev_reg     <= 1'b0;
            evp_reg    <= '0;
            wb_reg     <= 1'b0;
            done_reg   <= 1'b0;
            status_reg <= '0;
            frame_reg  <= '0;
            rpage_reg  <= '0;
            evo_reg    <= 1'b0;
            evpo_reg   <= '0;
            wbo_reg    <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            op_reg     <= op_next;
            pg_reg     <= pg_next;
            wr_reg     <= wr_next;
            hand_reg   <= hand_next;
            occ_reg    <= occ_next;
            idx_reg    <= idx_next;
            limit_reg  <= limit_next;
            init_reg   <= init_next;
            ev_reg     <= ev_next;
            evp_reg    <= evp_next;
            wb_reg     <= wb_next;
            done_reg   <= done_next;
            status_reg <= status_next;
            frame_reg  <= frame_next;
            rpage_reg  <= rpage_next;
            evo_reg    <= evo_next;
            evpo_reg   <= evpo_next;
            wbo_reg    <= wbo_next;
        end
    end

    // Page store: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (pm_we)
            page_mem[pm_waddr] <= pm_wdata;
        pm_rdata <= page_mem[pm_raddr];
    end

    // Allocation store
    always_ff @(posedge clk)
    begin
        if (am_we)
            alloc_mem[am_waddr] <= am_wdata;
        am_rdata <= alloc_mem[am_raddr];
    end

    // Frame owner store, read at the hand
    always_ff @(posedge clk)
    begin
        if (om_we)
            owner_mem[hand_reg] <= pg_addr;
        om_rdata <= owner_mem[hand_reg];
    end

    assign done         = done_reg;
    assign status       = status_reg;
    assign frame        = frame_reg;
    assign result_page  = rpage_reg;
    assign evicted      = evo_reg;
    assign evicted_page = evpo_reg;
    assign write_back   = wbo_reg;

endmodule

// ----- rtl/cpr_checker.sv -----
// Port-level checks for the clock page replacement unit, bound to the top level.
module cpr_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        start,
    input logic                        busy,
    input logic                        done,
    input logic [1:0]                  status,
    input logic [cpr_pkg::FRAME_W-1:0] frame,
    input logic                        evicted,
    input logic [cpr_pkg::PAGE_W-1:0]  evicted_page,
    input logic                        write_back
);

    // A result only follows a request in progress
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result without a request in progress");

    // An accepted request holds the unit busy
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("unit not busy after accepting a request");

    // Failures carry no frame and no eviction
    a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != cpr_pkg::ST_OK) |-> (!evicted && frame == '0))
        else $error("failed request reports a frame or eviction");

    // Write-back and evicted page only with an eviction
    a_wb_needs_evict: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !evicted) |-> (!write_back && evicted_page == '0))
        else $error("write-back without eviction");

endmodule

bind clock_page_replacement_unit cpr_checker u_cpr_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .done         (done),
    .status       (status),
    .frame        (frame),
    .evicted      (evicted),
    .evicted_page (evicted_page),
    .write_back   (write_back)
);

// ----- bench/clock_page_replacement_unit_tb.sv -----
// Self-checking bench for the clock page replacement unit with its own page-table predictor.
`timescale 1ns / 100ps

module clock_page_replacement_unit_tb;

    localparam int FRAMES = cpr_pkg::FRAME_COUNT;
    localparam int PAGES  = cpr_pkg::PAGE_COUNT;
    localparam int STALL_LIMIT = 20000;

    typedef struct packed {
        logic [1:0]                  status;
        logic [cpr_pkg::FRAME_W-1:0] frame;
        logic [cpr_pkg::PAGE_W-1:0]  result_page;
        logic                        evicted;
        logic [cpr_pkg::PAGE_W-1:0]  evicted_page;
        logic                        write_back;
    } page_result_t;

    // Page table predictor with a queue of expected results
    class page_table_scoreboard;
        bit          valid [PAGES];
        bit          refd  [PAGES];
        bit          dirty [PAGES];
        bit          alloc [PAGES];
        int          pframe[PAGES];
        bit          used  [FRAMES];
        int          owner [FRAMES];
        int          hand;
        int          init_pages;
        page_result_t pending[$];
        int          mismatches;
        int          checked;
        int          faults, evictions, segfaults, map_fails;

        function void reset_state();
            for (int i = 0; i < PAGES; i++)
            begin
                valid[i] = 0; refd[i] = 0; dirty[i] = 0; alloc[i] = 0; pframe[i] = 0;
            end
            for (int i = 0; i < FRAMES; i++)
            begin
                used[i] = 0; owner[i] = 0;
            end
            hand = 0;
            init_pages = 0;
        endfunction

        function void set_initial(int value);
            init_pages = value & 11'h7ff;
            for (int i = 0; i < init_pages && i < PAGES; i++)
                alloc[i] = 1;
        endfunction

        function void note_request(logic [1:0] op, int pg, bit wr);
            page_result_t r;
            int h;
            int v;
            r = '0;
            case (op)
                cpr_pkg::OP_FAULT:
                begin
                    r.result_page = cpr_pkg::PAGE_W'(pg);
                    if (!alloc[pg])
                    begin
                        r.status = cpr_pkg::ST_SEGFAULT;
                        segfaults++;
                    end
                    else if (valid[pg])
                        r.frame = cpr_pkg::FRAME_W'(pframe[pg]);
                    else
                    begin
                        h = hand;
                        for (int i = 0; i <= FRAMES; i++)
                        begin
                            if (!used[h] || !refd[owner[h]])
                                break;
                            refd[owner[h]] = 0;
                            h = (h + 1) % FRAMES;
                        end
                        if (used[h])
                        begin
                            v = owner[h];
                            valid[v] = 0;
                            refd[v] = 0;
                            r.evicted = 1;
                            r.evicted_page = cpr_pkg::PAGE_W'(v);
                            r.write_back = dirty[v];
                            evictions++;
                        end
                        valid[pg] = 1; refd[pg] = 0; dirty[pg] = 0;
                        pframe[pg] = h;
                        used[h] = 1;
                        owner[h] = pg;
                        hand = (h + 1) % FRAMES;
                        r.frame = cpr_pkg::FRAME_W'(h);
                        faults++;
                    end
                end
                cpr_pkg::OP_MAP:
                begin
                    r.status = cpr_pkg::ST_NO_FREE;
                    for (int i = init_pages; i < PAGES; i++)
                        if (!alloc[i])
                        begin
                            alloc[i] = 1;
                            r.result_page = cpr_pkg::PAGE_W'(i);
                            r.status = cpr_pkg::ST_OK;
                            break;
                        end
                    if (r.status == cpr_pkg::ST_NO_FREE)
                        map_fails++;
                end
                cpr_pkg::OP_UNMAP:
                begin
                    r.result_page = cpr_pkg::PAGE_W'(pg);
                    if (alloc[pg])
                    begin
                        if (valid[pg] && used[pframe[pg]] && owner[pframe[pg]] == pg)
                            used[pframe[pg]] = 0;
                        valid[pg] = 0; refd[pg] = 0; dirty[pg] = 0; alloc[pg] = 0;
                    end
                end
                default:
                begin
                    if (valid[pg])
                    begin
                        refd[pg] = 1;
                        if (wr)
                            dirty[pg] = 1;
                    end
                end
            endcase
            pending.push_back(r);
        endfunction

        function void check_result(page_result_t got);
            page_result_t want;
            checked++;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result with nothing expected: %p", got);
                return;
            end
            want = pending.pop_front();
            if (got !== want)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected %p got %p", want, got);
            end
        endfunction
    endclass

    logic                        clk;
    logic                        rst_n;
    logic                        start;
    logic                        busy;
    logic [1:0]                  operation;
    logic [cpr_pkg::PAGE_W-1:0]  page;
    logic                        is_write;
    logic                        done;
    logic [1:0]                  status;
    logic [cpr_pkg::FRAME_W-1:0] frame;
    logic [cpr_pkg::PAGE_W-1:0]  result_page;
    logic                        evicted;
    logic [cpr_pkg::PAGE_W-1:0]  evicted_page;
    logic                        write_back;
    logic                        psel;
    logic                        penable;
    logic                        pwrite;
    logic [2:0]                  paddr;
    logic [31:0]                 pwdata;
    logic [31:0]                 prdata;
    logic                        pready;

    page_table_scoreboard sb;
    int idle_pct;
    int quiet_cycles;
    int accepted;

    clock_page_replacement_unit dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .operation(operation), .page(page), .is_write(is_write),
        .done(done), .status(status), .frame(frame), .result_page(result_page),
        .evicted(evicted), .evicted_page(evicted_page), .write_back(write_back),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // Clock
    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // Check results and track acceptance at the rising edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done || (psel && penable && pwrite && pready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (start && !busy)
            begin
                sb.note_request(operation, page, is_write);
                accepted <= accepted + 1;
            end
            if (done)
                sb.check_result({status, frame, result_page, evicted, evicted_page,
                                 write_back});
        end
    end

    // Watchdog on a stalled run
    always @(posedge clk)
    begin
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("clock_page_replacement_unit_tb: errors");
            $finish;
        end
    end

    // Issue one request; drop start only while idling, hold it until taken
    task automatic send_request(logic [1:0] op, int pg, bit wr);
        if ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
            while ($urandom_range(99) < idle_pct)
                @(negedge clk);
        end
        start <= 1'b1;
        operation <= op;
        page <= cpr_pkg::PAGE_W'(pg);
        is_write <= wr;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Drop start, wait until every expected result has come, then let the unit settle
    task automatic drain();
        start <= 1'b0;
        while (sb.pending.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
        while (busy)
            @(negedge clk);
    endtask

    // Write initial_pages while the unit is idle
    task automatic write_initial(int value);
        drain();
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= 3'(4 * cpr_pkg::REG_INITIAL_PAGES);
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        sb.set_initial(value);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge clk);
        while (busy)
            @(negedge clk);
    endtask

    // Pick a page: mostly from a small working set starting at the initial count, or at PAGES - 100 if lower
    function automatic int pick_page();
        int base;
        base = (sb.init_pages < PAGES - 100) ? sb.init_pages : PAGES - 100;
        if ($urandom_range(9) < 8)
            return base + $urandom_range(99);
        return $urandom_range(PAGES - 1);
    endfunction

    task automatic random_phase(int count);
        int roll;
        for (int n = 0; n < count; n++)
        begin
            roll = $urandom_range(99);
            if (roll < 30)
                send_request(cpr_pkg::OP_FAULT, pick_page(), 1'($urandom_range(1)));
            else if (roll < 45)
                send_request(cpr_pkg::OP_MAP, $urandom_range(PAGES - 1),
                             1'($urandom_range(1)));
            else if (roll < 55)
                send_request(cpr_pkg::OP_UNMAP, pick_page(), 1'($urandom_range(1)));
            else
                send_request(cpr_pkg::OP_ACCESS, pick_page(), 1'($urandom_range(1)));
        end
    endtask

    initial
    begin
        sb = new();
        sb.reset_state();
        rst_n = 1'b0;
        start = 1'b0;
        operation = cpr_pkg::OP_FAULT;
        page = '0;
        is_write = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        quiet_cycles = 0;
        accepted = 0;
        idle_pct = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        while (busy)
            @(negedge clk);

        // Directed: segfault, maps, faults, hits, access, unmap, extreme pages
        send_request(cpr_pkg::OP_FAULT, 0, 0);
        send_request(cpr_pkg::OP_FAULT, PAGES - 1, 1);
        send_request(cpr_pkg::OP_MAP, 0, 0);
        send_request(cpr_pkg::OP_MAP, 0, 1);
        send_request(cpr_pkg::OP_FAULT, 0, 0);
        send_request(cpr_pkg::OP_FAULT, 0, 0);
        send_request(cpr_pkg::OP_ACCESS, 0, 1);
        send_request(cpr_pkg::OP_ACCESS, 1, 0);
        send_request(cpr_pkg::OP_FAULT, 1, 0);
        send_request(cpr_pkg::OP_UNMAP, 0, 0);
        send_request(cpr_pkg::OP_UNMAP, PAGES - 1, 1);
        send_request(cpr_pkg::OP_ACCESS, PAGES - 1, 1);
        write_initial(PAGES);
        send_request(cpr_pkg::OP_MAP, 0, 0);
        send_request(cpr_pkg::OP_FAULT, PAGES - 1, 0);
        send_request(cpr_pkg::OP_ACCESS, PAGES - 1, 1);
        send_request(cpr_pkg::OP_UNMAP, PAGES - 1, 0);
        send_request(cpr_pkg::OP_MAP, 0, 0);
        write_initial(11'h7ff);
        send_request(cpr_pkg::OP_MAP, 0, 0);
        // Fill every frame, reference them all, then force a full sweep
        for (int i = 0; i <= FRAMES; i++)
            send_request(cpr_pkg::OP_FAULT, i, 0);
        for (int i = 1; i <= FRAMES; i++)
            send_request(cpr_pkg::OP_ACCESS, i, 1'(i & 1));
        send_request(cpr_pkg::OP_FAULT, 200, 0);
        send_request(cpr_pkg::OP_FAULT, 0, 0);

        // Random phases under changing settings and idling
        write_initial(0);
        idle_pct = 35;
        random_phase(400);
        drain();
        write_initial(512);
        idle_pct = 57;
        random_phase(400);
        write_initial(930);
        idle_pct = 0;
        random_phase(320);
        write_initial(0);
        random_phase(100);

        drain();
        repeat (20) @(negedge clk);
        $display("covered %0d requests: %0d fault loads, %0d evictions, %0d segfaults,",
                 accepted, sb.faults, sb.evictions, sb.segfaults);
        $display("  %0d map failures, %0d results checked", sb.map_fails, sb.checked);
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("clock_page_replacement_unit_tb: clean");
        else
            $display("clock_page_replacement_unit_tb: errors");
        $finish;
    end

endmodule

// ----- clock_page_replacement_unit.f -----
rtl/cpr_pkg.sv
rtl/clock_page_replacement_unit.sv
rtl/cpr_checker.sv
bench/clock_page_replacement_unit_tb.sv
